@@ rtl/kdeq_pkg.sv @@
package kdeq_pkg;

	localparam int FT_W   = 7;
	localparam int LT_W   = 16;
	localparam int SP_W   = 8;
	localparam int CNT_W  = 8;
	localparam int CODE_W = 6;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [FT_W-1:0]  FT_RESET  = FT_W'(5);
	localparam logic [LT_W-1:0]  LT_RESET  = LT_W'(100);
	localparam logic [SP_W-1:0]  SP_RESET  = SP_W'(10);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(5 / 2);

	// register indexes (word address bits)
	localparam logic [1:0] REG_FILTER = 2'd0;
	localparam logic [1:0] REG_LONG   = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	// events one key raises on one scan: press or release, then long press
	typedef struct packed {
		logic              ev0;
		logic [CODE_W-1:0] code0;
		logic              ev1;
		logic [CODE_W-1:0] code1;
	} lane_ev_t;

	typedef struct packed {
		logic busy;
		logic hit;
		logic overflow;
	} merge_stat_t;

endpackage

@@ rtl/key_debounce_event_queue.sv @@
// Key debounce with press, release and long-press events in a FIFO.
// Each input transaction is either a tick (tuser = 0, tdata carries one raw
// level bit per key, 1 = pressed) or a pop (tuser = 1). Every scan_period
// ticks all keys are scanned at once, one debounce lane per key, and the
// events they raise (press 3k+1, release 3k+2, long press 3k+3) are merged
// into the event FIFO in key order, one write per cycle. When the FIFO is
// full a new event is dropped and the sticky overflow bit is set; only reset
// clears it. Every input transaction returns exactly one output transaction:
// the popped event code (0 for a tick or an empty FIFO) and the overflow bit
// as it stands after the transaction. Timing: the input takes one transaction
// at a time and is ready again in the same cycle in which the result of the
// last one is loaded into the output register. A pop or a tick without scan
// waits only for that register to be free; a scanning tick first waits until
// the merge has handled every event raised, up to 2*NUM_KEYS, through the
// single FIFO write port. The result sits in an output register, so the next
// transaction is accepted while the previous result waits; a stalled output
// holds back only the completion of the following one. Registers live on the
// APB port at byte addresses 0 (filter_time), 4 (long_time) and 8 (scan_period).
module key_debounce_event_queue #(
	parameter int NUM_KEYS   = 2,
	parameter int FIFO_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((NUM_KEYS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // key_levels
	input  logic                                  s_axis_tuser,  // func
	// master stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [7:0]                            m_axis_tdata,  // event_code, overflow
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [kdeq_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [kdeq_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [kdeq_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);
	import kdeq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_BUSY = 1'b1;

	logic [FT_W-1:0]   filter_q;
	logic [LT_W-1:0]   long_q;
	logic [SP_W-1:0]   period_q;
	logic [SP_W-1:0]   presc_q, presc_inc;
	logic              state_q;
	logic              is_pop_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_ovf_q;
	logic              in_acc, tick_acc, scan, pop, wr_en, out_free, finish;
	lane_ev_t          lane_ev [NUM_KEYS];
	merge_stat_t       mst;
	logic [CODE_W-1:0] rd_code;

	// configuration: write on the access phase, read back combinationally
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= FT_RESET;
			long_q   <= LT_RESET;
			period_q <= SP_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FILTER: filter_q <= pwdata[FT_W-1:0];
				REG_LONG:   long_q   <= pwdata[LT_W-1:0];
				REG_PERIOD: period_q <= pwdata[SP_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FILTER: prdata = APB_DATA_W'(filter_q);
			REG_LONG:   prdata = APB_DATA_W'(long_q);
			REG_PERIOD: prdata = APB_DATA_W'(period_q);
			default:    prdata = '0;
		endcase
	end

	// input side: one transaction at a time
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign tick_acc      = in_acc && !s_axis_tuser;
	assign pop           = in_acc && s_axis_tuser;

	// prescaler: advance on ticks only, scan when it reaches the period
	assign presc_inc = presc_q + 1'b1;
	assign scan      = tick_acc && (presc_inc >= period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= '0;
		end else if (tick_acc) begin
			presc_q <= scan ? '0 : presc_inc;
		end
	end

	// one debounce lane per key, all updated on the same scan
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kdeq_lane #(
			.KEY_IDX (k)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.scan        (scan),
			.level       (s_axis_tdata[k]),
			.filter_time (filter_q),
			.long_time   (long_q),
			.ev          (lane_ev[k])
		);
	end

	// merge lane events into the FIFO in key order and serve pops
	kdeq_merge #(
		.NUM_KEYS   (NUM_KEYS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (scan),
		.ev      (lane_ev),
		.pop     (pop),
		.stat    (mst),
		.rd_code (rd_code)
	);

	// finish once the merge has drained and the output register is free
	assign out_free = !out_valid_q || m_axis_tready;
	assign finish   = (state_q == S_BUSY) && !mst.busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			is_pop_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q  <= S_BUSY;
				is_pop_q <= s_axis_tuser;
			end else if (finish) begin
				state_q <= S_IDLE;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_code_q <= (is_pop_q && mst.hit) ? rd_code : '0;
			out_ovf_q  <= mst.overflow;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_ovf_q, out_code_q};

`ifndef SYNTHESIS
	// no pending FIFO writes while a new transaction may be accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !mst.busy)
		else $error("merge still draining while input is ready");

	// overflow is sticky until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		mst.overflow |=> mst.overflow)
		else $error("overflow flag cleared without reset");

	// an accepted transaction always enters the busy state
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_BUSY))
		else $error("accepted transaction not in progress");
`endif

endmodule

@@ rtl/kdeq_lane.sv @@
module kdeq_lane #(
	parameter int KEY_IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       scan,
	input  logic                       level,
	input  logic [kdeq_pkg::FT_W-1:0]  filter_time,
	input  logic [kdeq_pkg::LT_W-1:0]  long_time,
	output kdeq_pkg::lane_ev_t         ev
);
	import kdeq_pkg::*;

	localparam logic [CODE_W-1:0] CODE_PRESS   = CODE_W'(3 * KEY_IDX + 1);
	localparam logic [CODE_W-1:0] CODE_RELEASE = CODE_W'(3 * KEY_IDX + 2);
	localparam logic [CODE_W-1:0] CODE_LONG    = CODE_W'(3 * KEY_IDX + 3);

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pressed_q, pressed_d;
	logic [LT_W-1:0]  hold_q, hold_d;
	logic [CNT_W-1:0] ft_ext, ft_dbl;

	assign ft_ext = {1'b0, filter_time};
	assign ft_dbl = {filter_time, 1'b0};

	always_comb begin
		cnt_d     = cnt_q;
		pressed_d = pressed_q;
		hold_d    = hold_q;
		ev        = '0;
		ev.code0  = CODE_PRESS;
		ev.code1  = CODE_LONG;
		if (level) begin
			if (cnt_q < ft_ext) begin
				cnt_d = ft_ext;
			end else if (cnt_q < ft_dbl) begin
				cnt_d = cnt_q + 1'b1;
			end else begin
				if (!pressed_q) begin
					pressed_d = 1'b1;
					ev.ev0    = 1'b1;
				end
				if ((long_time != '0) && (hold_q < long_time)) begin
					hold_d = hold_q + 1'b1;
					ev.ev1 = (hold_d == long_time);
				end
			end
		end else begin
			if (cnt_q > ft_ext) begin
				cnt_d = ft_ext;
			end else if (cnt_q != '0) begin
				cnt_d = cnt_q - 1'b1;
			end else if (pressed_q) begin
				pressed_d = 1'b0;
				ev.ev0    = 1'b1;
				ev.code0  = CODE_RELEASE;
			end
			hold_d = '0;
		end
		if (!scan) begin
			ev.ev0 = 1'b0;
			ev.ev1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CNT_RESET;
			pressed_q <= 1'b0;
			hold_q    <= '0;
		end else if (scan) begin
			cnt_q     <= cnt_d;
			pressed_q <= pressed_d;
			hold_q    <= hold_d;
		end
	end

endmodule

@@ rtl/kdeq_merge.sv @@
module kdeq_merge #(
	parameter int NUM_KEYS   = 2,
	parameter int FIFO_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  kdeq_pkg::lane_ev_t           ev [NUM_KEYS],
	input  logic                         pop,
	output kdeq_pkg::merge_stat_t        stat,
	output logic [kdeq_pkg::CODE_W-1:0]  rd_code
);
	import kdeq_pkg::*;

	localparam int SLOTS = 2 * NUM_KEYS;
	localparam int SW    = $clog2(SLOTS);
	localparam int AW    = $clog2(FIFO_DEPTH);
	localparam int FW    = $clog2(FIFO_DEPTH + 1);

	logic [SLOTS-1:0]  pend_q;
	logic [CODE_W-1:0] code_q [SLOTS];
	logic [CODE_W-1:0] mem [FIFO_DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [FW-1:0]     fill_q;
	logic              ovf_q, hit_q;
	logic [CODE_W-1:0] rd_code_q;
	logic [SW-1:0]     sel;
	logic              full, push, pop_do;

	// lowest pending slot goes first: key order, press/release before long
	always_comb begin
		sel = '0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (pend_q[j]) begin
				sel = SW'(j);
			end
		end
	end

	assign full   = (fill_q == FW'(FIFO_DEPTH));
	assign push   = (|pend_q) && !full;
	assign pop_do = pop && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				code_q[2*k]   <= ev[k].code0;
				code_q[2*k+1] <= ev[k].code1;
			end
		end
		if (push) begin
			mem[wr_q] <= code_q[sel];
		end
		if (pop_do) begin
			rd_code_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (load) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					pend_q[2*k]   <= ev[k].ev0;
					pend_q[2*k+1] <= ev[k].ev1;
				end
			end else if (|pend_q) begin
				pend_q[sel] <= 1'b0;
				if (full) begin
					ovf_q <= 1'b1;
				end
			end
			if (push) begin
				wr_q   <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end else if (pop_do) begin
				rd_q   <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end
			if (pop) begin
				hit_q <= pop_do;
			end
		end
	end

	assign stat.busy     = |pend_q;
	assign stat.hit      = hit_q;
	assign stat.overflow = ovf_q;
	assign rd_code       = rd_code_q;

endmodule

@@ bench/tb_key_debounce_event_queue.sv @@
module tb_key_debounce_event_queue;
	import kdeq_pkg::*;

	localparam int NUM_KEYS   = 2;
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	// operation carried in tuser
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// event code offsets within one key's group of three
	localparam int EV_PRESS   = 1;
	localparam int EV_RELEASE = 2;
	localparam int EV_LONG    = 3;
	localparam logic [CODE_W-1:0] EV_NONE = '0;

	// one index past the register list, left unmapped
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int HOLDOFF_CYCLES = 300;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASES         = 6;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              ovf;
	} key_result_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_POP, ROW_WRITE} row_kind_t;

	// arg is the key levels for a tick or pop, the register index for a write
	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        arg;
		logic [15:0]       value;
		logic              typed;
		logic [CODE_W-1:0] code;
		logic              ovf;
	} stim_row_t;

	localparam int N_ROWS = 29;

	// Directed table. Rows with typed = 1 carry their own expected result;
	// all other items are checked against the predictor.
	stim_row_t dir_rows [N_ROWS] = '{
		'{ROW_POP,   2'd0,       16'd0,     1'b1, EV_NONE,  1'b0}, // pop on empty queue
		'{ROW_TICK,  2'd3,       16'd0,     1'b1, EV_NONE,  1'b0}, // prescaler not due yet
		'{ROW_WRITE, REG_FILTER, 16'd0,     1'b0, EV_NONE,  1'b0}, // zero filter: instant
		'{ROW_WRITE, REG_LONG,   16'd1,     1'b0, EV_NONE,  1'b0},
		'{ROW_WRITE, REG_PERIOD, 16'd0,     1'b0, EV_NONE,  1'b0}, // zero period: every tick
		'{ROW_TICK,  2'd3,       16'd0,     1'b1, EV_NONE,  1'b0}, // press + long, both keys
		'{ROW_TICK,  2'd0,       16'd0,     1'b0, EV_NONE,  1'b0}, // counters drop to zero
		'{ROW_TICK,  2'd0,       16'd0,     1'b0, EV_NONE,  1'b0}, // release both keys
		'{ROW_TICK,  2'd3,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_TICK,  2'd0,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_TICK,  2'd3,       16'd0,     1'b0, EV_NONE,  1'b0}, // queue now full
		'{ROW_TICK,  2'd0,       16'd0,     1'b1, EV_NONE,  1'b1}, // releases dropped
		'{ROW_POP,   2'd1,       16'd0,     1'b1, 6'd1,     1'b1}, // key 0 press first
		'{ROW_POP,   2'd2,       16'd0,     1'b1, 6'd3,     1'b1}, // then key 0 long
		'{ROW_WRITE, REG_SPARE,  16'h007f,  1'b0, EV_NONE,  1'b0}, // unmapped: ignored
		'{ROW_WRITE, REG_FILTER, 16'd127,   1'b0, EV_NONE,  1'b0},
		'{ROW_WRITE, REG_LONG,   16'hffff,  1'b0, EV_NONE,  1'b0},
		'{ROW_WRITE, REG_PERIOD, 16'd255,   1'b0, EV_NONE,  1'b0},
		'{ROW_TICK,  2'd1,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_TICK,  2'd2,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_WRITE, REG_PERIOD, 16'd1,     1'b0, EV_NONE,  1'b0},
		'{ROW_TICK,  2'd1,       16'd0,     1'b0, EV_NONE,  1'b0}, // key 0 jumps to 127
		'{ROW_TICK,  2'd1,       16'd0,     1'b0, EV_NONE,  1'b0}, // and climbs to 128
		'{ROW_WRITE, REG_FILTER, 16'd1,     1'b0, EV_NONE,  1'b0}, // counter now above 2*ft
		'{ROW_TICK,  2'd1,       16'd0,     1'b0, EV_NONE,  1'b0}, // treated as debounced
		'{ROW_TICK,  2'd2,       16'd0,     1'b0, EV_NONE,  1'b0}, // release drops to ft
		'{ROW_POP,   2'd3,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_POP,   2'd0,       16'd0,     1'b0, EV_NONE,  1'b0},
		'{ROW_POP,   2'd1,       16'd0,     1'b0, EV_NONE,  1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata = '0;   // key_levels
	logic                        s_axis_tuser = 1'b0; // func
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [7:0]                  m_axis_tdata;        // event_code, overflow
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]       paddr = '0;
	logic [APB_DATA_W-1:0]       pwdata = '0;
	logic [APB_DATA_W-1:0]       prdata;
	logic                        pready;

	key_debounce_event_queue #(
		.NUM_KEYS   (NUM_KEYS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// Shadow copy of the registers and of the block's state
	logic [FT_W-1:0]   cfg_filter = FT_RESET;
	logic [LT_W-1:0]   cfg_long   = LT_RESET;
	logic [SP_W-1:0]   cfg_period = SP_RESET;
	logic [SP_W-1:0]   scan_div = '0;
	logic [CNT_W-1:0]  filt_cnt [NUM_KEYS];
	logic              key_down [NUM_KEYS];
	logic [LT_W-1:0]   held_scans [NUM_KEYS];
	logic [CODE_W-1:0] ev_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  ev_wr = '0;
	logic [PTR_W-1:0]  ev_rd = '0;
	logic [PTR_W:0]    ev_fill = '0;
	logic              ev_lost = 1'b0;

	initial begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			filt_cnt[k] = CNT_RESET;
			key_down[k] = 1'b0;
			held_scans[k] = '0;
		end
	end

	key_result_t due_results [$];
	int fail_count = 0;
	int send_idle = 29;
	int recv_idle = 53;
	int holdoff_req = 0;
	int cycles = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	// Push one event; drop it and flag overflow when the queue is full.
	function automatic void queue_event(input logic [CODE_W-1:0] c);
		if (ev_fill >= FIFO_DEPTH) begin
			ev_lost = 1'b1;
		end else begin
			ev_mem[ev_wr] = c;
			ev_wr = ev_wr + 1'b1;
			ev_fill = ev_fill + 1'b1;
		end
	endfunction

	// Hysteresis debounce of one key on one scan, 0 .. 2*filter_time.
	function automatic void scan_one_key(input int k, input logic lvl);
		int top;
		top = 2 * int'(cfg_filter);
		if (lvl) begin
			if (filt_cnt[k] < CNT_W'(cfg_filter)) begin
				filt_cnt[k] = CNT_W'(cfg_filter);
			end else if (int'(filt_cnt[k]) < top) begin
				filt_cnt[k] = filt_cnt[k] + 1'b1;
			end else begin
				if (!key_down[k]) begin
					key_down[k] = 1'b1;
					queue_event(CODE_W'(3 * k + EV_PRESS));
				end
				// long press fires once, when the hold count reaches long_time
				if (cfg_long != 0 && held_scans[k] < cfg_long) begin
					held_scans[k] = held_scans[k] + 1'b1;
					if (held_scans[k] == cfg_long)
						queue_event(CODE_W'(3 * k + EV_LONG));
				end
			end
		end else begin
			if (filt_cnt[k] > CNT_W'(cfg_filter)) begin
				filt_cnt[k] = CNT_W'(cfg_filter);
			end else if (filt_cnt[k] != 0) begin
				filt_cnt[k] = filt_cnt[k] - 1'b1;
			end else if (key_down[k]) begin
				key_down[k] = 1'b0;
				queue_event(CODE_W'(3 * k + EV_RELEASE));
			end
			held_scans[k] = '0;
		end
	endfunction

	// Advance the shadow state by one accepted transaction and return its result.
	function automatic key_result_t predict_key_result(input logic fn, input logic [1:0] lv);
		key_result_t r;
		r.code = EV_NONE;
		if (fn == FUNC_TICK) begin
			scan_div = scan_div + 1'b1;
			if (scan_div >= cfg_period) begin
				scan_div = '0;
				for (int k = 0; k < NUM_KEYS; k++)
					scan_one_key(k, lv[k]);
			end
		end else if (ev_fill != 0) begin
			r.code = ev_mem[ev_rd];
			ev_rd = ev_rd + 1'b1;
			ev_fill = ev_fill - 1'b1;
		end
		r.ovf = ev_lost;
		return r;
	endfunction

	// Offer one transaction, hold it until accepted, then log its expected result.
	// Leave tvalid high when the next transaction follows at once.
	task automatic send_item(input logic fn, input logic [1:0] lv, input logic typed,
			input logic [CODE_W-1:0] t_code, input logic t_ovf);
		key_result_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= 8'(lv);
		do @(posedge clk); while (!s_axis_tready);
		r = predict_key_result(fn, lv);
		if (typed) begin
			r.code = t_code;
			r.ovf = t_ovf;
		end
		due_results.push_back(r);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Drop tvalid, wait until every expected result is back, then let the
	// last FIFO writes settle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write, then, for a mapped register, read it back through a second transfer.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] want;
		logic mapped;
		logic done;
		mapped = 1'b1;
		want = '0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_FILTER: begin
				cfg_filter = value[FT_W-1:0];
				want = 32'(cfg_filter);
			end
			REG_LONG: begin
				cfg_long = value[LT_W-1:0];
				want = 32'(cfg_long);
			end
			REG_PERIOD: begin
				cfg_period = value[SP_W-1:0];
				want = 32'(cfg_period);
			end
			default: mapped = 1'b0;
		endcase
		if (mapped) begin
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			// sample prdata mid-cycle during the access phase
			do begin
				@(negedge clk);
				done = pready;
				if (done && prdata != want)
					report("register readback", longint'(prdata), longint'(want));
				@(posedge clk);
			end while (!done);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: random tready, or a long hold-off on request so the block
	// fills up and stalls its input.
	initial begin
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req != served) begin
				served = holdoff_req;
				m_axis_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Compare every accepted output transaction with the oldest expectation.
	always @(posedge clk) begin
		key_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				report("event_code with nothing due", longint'(m_axis_tdata[CODE_W-1:0]),
					longint'(EV_NONE));
			end else begin
				exp_r = due_results.pop_front();
				if (m_axis_tdata[CODE_W-1:0] !== exp_r.code)
					report("event_code", longint'(m_axis_tdata[CODE_W-1:0]),
						longint'(exp_r.code));
				if (m_axis_tdata[CODE_W] !== exp_r.ovf)
					report("overflow", longint'(m_axis_tdata[CODE_W]), longint'(exp_r.ovf));
			end
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int pop_pct;
		int run_left;
		logic [1:0] pattern;
		logic [1:0] lv;
		logic [31:0] f_val;
		logic [31:0] l_val;
		logic [31:0] p_val;
		run_left = 0;
		pattern = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_WRITE: begin
					settle();
					write_reg(dir_rows[i].arg, 32'(dir_rows[i].value));
				end
				ROW_POP: send_item(FUNC_POP, dir_rows[i].arg, dir_rows[i].typed,
						dir_rows[i].code, dir_rows[i].ovf);
				default: send_item(FUNC_TICK, dir_rows[i].arg, dir_rows[i].typed,
						dir_rows[i].code, dir_rows[i].ovf);
			endcase
		end

		// Random part: phases with their own settings and idle pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin f_val = 1;   l_val = 4;     p_val = 1;   end
				1: begin f_val = 2;   l_val = 0;     p_val = 3;   end
				2: begin
					f_val = $urandom_range(1, 4);
					l_val = $urandom_range(1, 30);
					p_val = $urandom_range(1, 4);
				end
				3: begin f_val = 127; l_val = 65535; p_val = 255; end
				4: begin f_val = 3;   l_val = 1;     p_val = 2;   end
				default: begin f_val = 1; l_val = 2; p_val = 1; end
			endcase
			settle();
			write_reg(REG_FILTER, f_val);
			write_reg(REG_LONG, l_val);
			write_reg(REG_PERIOD, p_val);

			// sender idles less than receiver, then swap, then no idling
			if (phase < 2) begin
				send_idle = 29;
				recv_idle = 53;
			end else if (phase < 4) begin
				send_idle = 53;
				recv_idle = 29;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end

			// last phase: rare pops and a long receiver hold-off
			pop_pct = (phase == PHASES - 1) ? 5 : 35;
			if (phase == PHASES - 1)
				holdoff_req++;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < pop_pct) begin
					send_item(FUNC_POP, 2'($urandom_range(3)), 1'b0, EV_NONE, 1'b0);
				end else begin
					// hold a key pattern for a stretch, with occasional bounce
					if (run_left == 0) begin
						pattern = 2'($urandom_range(3));
						run_left = $urandom_range(1, 40);
					end
					run_left--;
					lv = ($urandom_range(99) < 8) ? 2'($urandom_range(3)) : pattern;
					send_item(FUNC_TICK, lv, 1'b0, EV_NONE, 1'b0);
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
